@@ rtl/i2c_rts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register transaction sequencer package
// Command, bus action, status and error codes and the phase type.
// ----------------------------------------------------------------------------
package i2c_rts_pkg;

    // Input commands
    localparam logic [1:0] CMD_BEGIN_WRITE = 2'd0;
    localparam logic [1:0] CMD_BEGIN_READ  = 2'd1;
    localparam logic [1:0] CMD_BUS_DONE    = 2'd2;

    // Bus unit actions
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_SEND   = 3'd2;
    localparam logic [2:0] ACT_RXACK  = 3'd3;
    localparam logic [2:0] ACT_RXNACK = 3'd4;
    localparam logic [2:0] ACT_STOP   = 3'd5;

    // Expected bus status codes (low three bits masked off)
    localparam logic [7:0] ST_START   = 8'h08;
    localparam logic [7:0] ST_ADDR    = 8'h18;
    localparam logic [7:0] ST_TXDATA  = 8'h28;
    localparam logic [7:0] ST_RESTART = 8'h10;
    localparam logic [7:0] ST_RADDR   = 8'h40;
    localparam logic [7:0] ST_RXACK   = 8'h50;
    localparam logic [7:0] ST_RXNACK  = 8'h58;
    localparam logic [7:0] ST_MASK    = 8'hF8;

    // Error codes reported at the end of a transaction
    localparam logic [3:0] ERR_OK      = 4'd0;
    localparam logic [3:0] ERR_START   = 4'd1;
    localparam logic [3:0] ERR_ADDR    = 4'd2;
    localparam logic [3:0] ERR_REG     = 4'd3;
    localparam logic [3:0] ERR_DATA    = 4'd4;
    localparam logic [3:0] ERR_RESTART = 4'd5;
    localparam logic [3:0] ERR_RADDR   = 4'd6;
    localparam logic [3:0] ERR_RXACK   = 4'd7;
    localparam logic [3:0] ERR_RXNACK  = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START   = 4'd1,
        PH_ADDR    = 4'd2,
        PH_REG     = 4'd3,
        PH_WDATA   = 4'd4,
        PH_RESTART = 4'd5,
        PH_RADDR   = 4'd6,
        PH_RACK    = 4'd7,
        PH_RNACK   = 4'd8
    } phase_t;

endpackage

@@ rtl/i2c_register_transaction_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C register transaction sequencer
// Drives a byte-level I2C bus unit through register writes and reads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries begin-write, begin-read and
//   bus-done items. A begin item taken in idle latches address, register and
//   byte count and yields a start action. Each bus-done item carries the bus
//   unit's status; the block checks it against the phase and yields the next
//   action (send, restart, receive, stop) or ends the transaction with an
//   error code and no stop.
//   Output channel (out_valid / out_stall) carries exactly one result per
//   input transfer, in order.
//   Path: an accepted transfer goes into the input register and then into
//   the result register when the output is free (one input register, one result register).
//   Throughput: one transfer per cycle while out_stall is low; the phase update is a single
//   compare and select between the input register and the result register.
//   Stall: while out_stall holds a result, the input register keeps one
//   more item and then in_stall rises; nothing is dropped.
//   Reset: rst_n clears both valid flags and returns the phase to idle with
//   all saved fields zero.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [7:0] device_address,
    input  logic [7:0] register_index,
    input  logic [7:0] byte_count,
    input  logic [7:0] write_byte,
    input  logic [7:0] bus_status,
    input  logic [7:0] read_byte,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] bus_action,
    output logic [7:0] tx_byte,
    output logic       rx_valid,
    output logic [7:0] rx_byte,
    output logic       done_res,
    output logic [3:0] error_code
);

    // Input register stage
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [1:0] s1_command_reg;
    logic [7:0] s1_address_reg;
    logic [7:0] s1_register_reg;
    logic [7:0] s1_count_reg;
    logic [7:0] s1_wbyte_reg;
    logic [7:0] s1_status_reg;
    logic [7:0] s1_rbyte_reg;

    // Transaction state
    i2c_rts_pkg::phase_t phase_reg;
    i2c_rts_pkg::phase_t phase_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic [7:0] saved_address_reg;
    logic [7:0] saved_address_next;
    logic [7:0] saved_register_reg;
    logic [7:0] saved_register_next;
    logic       is_read_reg;
    logic       is_read_next;

    // Result register stage
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [2:0] bus_action_reg;
    logic [2:0] bus_action_next;
    logic [7:0] tx_byte_reg;
    logic [7:0] tx_byte_next;
    logic       rx_valid_reg;
    logic       rx_valid_next;
    logic [7:0] rx_byte_reg;
    logic [7:0] rx_byte_next;
    logic       done_res_reg;
    logic       done_res_next;
    logic [3:0] error_code_reg;
    logic [3:0] error_code_next;

    logic       in_take;
    logic       s1_advance;
    logic       is_begin;
    logic       is_done;
    logic [7:0] status_masked;
    logic [7:0] status_expected;
    logic       status_ok;
    logic [7:0] bytes_dec;

    // Handshake: advance the input register whenever the result register is
    // empty or its transfer completes this cycle.
    assign s1_advance    = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall      = s1_valid_reg & ~s1_advance;
    assign in_take       = in_valid & ~in_stall;
    assign s1_valid_next = in_take | (s1_valid_reg & ~s1_advance);
    assign out_valid_next = s1_advance | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming transfer
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_command_reg  <= command;
            s1_address_reg  <= device_address;
            s1_register_reg <= register_index;
            s1_count_reg    <= byte_count;
            s1_wbyte_reg    <= write_byte;
            s1_status_reg   <= bus_status;
            s1_rbyte_reg    <= read_byte;
        end
    end

    // Decode and status check
    assign is_begin = (s1_command_reg == i2c_rts_pkg::CMD_BEGIN_WRITE) ||
                      (s1_command_reg == i2c_rts_pkg::CMD_BEGIN_READ);
    assign is_done  = (s1_command_reg == i2c_rts_pkg::CMD_BUS_DONE);
    assign status_masked = s1_status_reg & i2c_rts_pkg::ST_MASK;
    assign bytes_dec     = bytes_left_reg - 8'd1;

    always_comb
    begin
        case (phase_reg)
            i2c_rts_pkg::PH_START:   status_expected = i2c_rts_pkg::ST_START;
            i2c_rts_pkg::PH_ADDR:    status_expected = i2c_rts_pkg::ST_ADDR;
            i2c_rts_pkg::PH_REG:     status_expected = i2c_rts_pkg::ST_TXDATA;
            i2c_rts_pkg::PH_WDATA:   status_expected = i2c_rts_pkg::ST_TXDATA;
            i2c_rts_pkg::PH_RESTART: status_expected = i2c_rts_pkg::ST_RESTART;
            i2c_rts_pkg::PH_RADDR:   status_expected = i2c_rts_pkg::ST_RADDR;
            i2c_rts_pkg::PH_RACK:    status_expected = i2c_rts_pkg::ST_RXACK;
            i2c_rts_pkg::PH_RNACK:   status_expected = i2c_rts_pkg::ST_RXNACK;
            default:                 status_expected = i2c_rts_pkg::ST_MASK;
        endcase
    end

    assign status_ok = (status_masked == status_expected);

    // Next state
    always_comb
    begin
        phase_next          = phase_reg;
        bytes_left_next     = bytes_left_reg;
        saved_address_next  = saved_address_reg;
        saved_register_next = saved_register_reg;
        is_read_next        = is_read_reg;

        if (is_begin)
        begin
            if (phase_reg == i2c_rts_pkg::PH_IDLE)
            begin
                saved_address_next  = s1_address_reg;
                saved_register_next = s1_register_reg;
                is_read_next        = (s1_command_reg == i2c_rts_pkg::CMD_BEGIN_READ);
                // A read of zero bytes still reads one
                if ((s1_command_reg == i2c_rts_pkg::CMD_BEGIN_READ) &&
                    (s1_count_reg == 8'd0))
                begin
                    bytes_left_next = 8'd1;
                end
                else
                begin
                    bytes_left_next = s1_count_reg;
                end
                phase_next = i2c_rts_pkg::PH_START;
            end
        end
        else if (is_done && (phase_reg != i2c_rts_pkg::PH_IDLE))
        begin
            if (!status_ok)
            begin
                phase_next = i2c_rts_pkg::PH_IDLE;
            end
            else
            begin
                case (phase_reg)
                    i2c_rts_pkg::PH_START:
                    begin
                        phase_next = i2c_rts_pkg::PH_ADDR;
                    end
                    i2c_rts_pkg::PH_ADDR:
                    begin
                        phase_next = i2c_rts_pkg::PH_REG;
                    end
                    i2c_rts_pkg::PH_REG, i2c_rts_pkg::PH_WDATA:
                    begin
                        if (is_read_reg && (phase_reg == i2c_rts_pkg::PH_REG))
                        begin
                            phase_next = i2c_rts_pkg::PH_RESTART;
                        end
                        else if (bytes_left_reg == 8'd0)
                        begin
                            phase_next = i2c_rts_pkg::PH_IDLE;
                        end
                        else
                        begin
                            bytes_left_next = bytes_dec;
                            phase_next      = i2c_rts_pkg::PH_WDATA;
                        end
                    end
                    i2c_rts_pkg::PH_RESTART:
                    begin
                        phase_next = i2c_rts_pkg::PH_RADDR;
                    end
                    i2c_rts_pkg::PH_RADDR:
                    begin
                        phase_next = (bytes_left_reg > 8'd1) ? i2c_rts_pkg::PH_RACK
                                                             : i2c_rts_pkg::PH_RNACK;
                    end
                    i2c_rts_pkg::PH_RACK:
                    begin
                        bytes_left_next = bytes_dec;
                        phase_next = (bytes_dec > 8'd1) ? i2c_rts_pkg::PH_RACK
                                                        : i2c_rts_pkg::PH_RNACK;
                    end
                    i2c_rts_pkg::PH_RNACK:
                    begin
                        bytes_left_next = 8'd0;
                        phase_next      = i2c_rts_pkg::PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = i2c_rts_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Result
    always_comb
    begin
        bus_action_next = i2c_rts_pkg::ACT_NONE;
        tx_byte_next    = 8'd0;
        rx_valid_next   = 1'b0;
        rx_byte_next    = 8'd0;
        done_res_next   = 1'b0;
        error_code_next = i2c_rts_pkg::ERR_OK;

        if (is_begin)
        begin
            if (phase_reg == i2c_rts_pkg::PH_IDLE)
            begin
                bus_action_next = i2c_rts_pkg::ACT_START;
            end
        end
        else if (is_done && (phase_reg != i2c_rts_pkg::PH_IDLE))
        begin
            case (phase_reg)
                i2c_rts_pkg::PH_START:
                begin
                    if (status_ok)
                    begin
                        bus_action_next = i2c_rts_pkg::ACT_SEND;
                        tx_byte_next    = saved_address_reg;
                    end
                    else
                    begin
                        done_res_next   = 1'b1;
                        error_code_next = i2c_rts_pkg::ERR_START;
                    end
                end
                i2c_rts_pkg::PH_ADDR:
                begin
                    if (status_ok)
                    begin
                        bus_action_next = i2c_rts_pkg::ACT_SEND;
                        tx_byte_next    = saved_register_reg;
                    end
                    else
                    begin
                        done_res_next   = 1'b1;
                        error_code_next = i2c_rts_pkg::ERR_ADDR;
                    end
                end
                i2c_rts_pkg::PH_REG, i2c_rts_pkg::PH_WDATA:
                begin
                    if (!status_ok)
                    begin
                        done_res_next   = 1'b1;
                        error_code_next = (phase_reg == i2c_rts_pkg::PH_REG)
                                          ? i2c_rts_pkg::ERR_REG : i2c_rts_pkg::ERR_DATA;
                    end
                    else if (is_read_reg && (phase_reg == i2c_rts_pkg::PH_REG))
                    begin
                        bus_action_next = i2c_rts_pkg::ACT_START;
                    end
                    else if (bytes_left_reg == 8'd0)
                    begin
                        bus_action_next = i2c_rts_pkg::ACT_STOP;
                        done_res_next   = 1'b1;
                    end
                    else
                    begin
                        bus_action_next = i2c_rts_pkg::ACT_SEND;
                        tx_byte_next    = s1_wbyte_reg;
                    end
                end
                i2c_rts_pkg::PH_RESTART:
                begin
                    if (status_ok)
                    begin
                        bus_action_next = i2c_rts_pkg::ACT_SEND;
                        tx_byte_next    = saved_address_reg + 8'd1;
                    end
                    else
                    begin
                        done_res_next   = 1'b1;
                        error_code_next = i2c_rts_pkg::ERR_RESTART;
                    end
                end
                i2c_rts_pkg::PH_RADDR:
                begin
                    if (status_ok)
                    begin
                        bus_action_next = (bytes_left_reg > 8'd1) ? i2c_rts_pkg::ACT_RXACK
                                                                  : i2c_rts_pkg::ACT_RXNACK;
                    end
                    else
                    begin
                        done_res_next   = 1'b1;
                        error_code_next = i2c_rts_pkg::ERR_RADDR;
                    end
                end
                i2c_rts_pkg::PH_RACK:
                begin
                    // Hand over the received byte even on error
                    rx_valid_next = 1'b1;
                    rx_byte_next  = s1_rbyte_reg;
                    if (status_ok)
                    begin
                        bus_action_next = (bytes_dec > 8'd1) ? i2c_rts_pkg::ACT_RXACK
                                                             : i2c_rts_pkg::ACT_RXNACK;
                    end
                    else
                    begin
                        done_res_next   = 1'b1;
                        error_code_next = i2c_rts_pkg::ERR_RXACK;
                    end
                end
                i2c_rts_pkg::PH_RNACK:
                begin
                    rx_valid_next = 1'b1;
                    rx_byte_next  = s1_rbyte_reg;
                    done_res_next = 1'b1;
                    if (status_ok)
                    begin
                        bus_action_next = i2c_rts_pkg::ACT_STOP;
                    end
                    else
                    begin
                        error_code_next = i2c_rts_pkg::ERR_RXNACK;
                    end
                end
                default:
                begin
                    bus_action_next = i2c_rts_pkg::ACT_NONE;
                end
            endcase
        end
    end

    // Commit state when the item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= i2c_rts_pkg::PH_IDLE;
            bytes_left_reg     <= 8'd0;
            saved_address_reg  <= 8'd0;
            saved_register_reg <= 8'd0;
            is_read_reg        <= 1'b0;
        end
        else if (s1_advance)
        begin
            phase_reg          <= phase_next;
            bytes_left_reg     <= bytes_left_next;
            saved_address_reg  <= saved_address_next;
            saved_register_reg <= saved_register_next;
            is_read_reg        <= is_read_next;
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            bus_action_reg <= bus_action_next;
            tx_byte_reg    <= tx_byte_next;
            rx_valid_reg   <= rx_valid_next;
            rx_byte_reg    <= rx_byte_next;
            done_res_reg   <= done_res_next;
            error_code_reg <= error_code_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign bus_action = bus_action_reg;
    assign tx_byte    = tx_byte_reg;
    assign rx_valid   = rx_valid_reg;
    assign rx_byte    = rx_byte_reg;
    assign done_res   = done_res_reg;
    assign error_code = error_code_reg;

endmodule
